### rtl/core/tcpr_pkg.sv
// Shared types and constants of the TCP Reno congestion window controller.
`default_nettype none

package tcpr_pkg;

   localparam int ACTION_W = 2;
   localparam int ACK_W    = 16;
   localparam int WIN_W    = 32;
   localparam int DUP_W    = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [WIN_W-1:0] WIN_MAX      = 32'hFFFF_FFFF;
   localparam logic [WIN_W-1:0] THRESH_RESET = 32'd2147483647;
   localparam logic [WIN_W-1:0] RECOV_BONUS  = 32'd3;
   localparam logic [DUP_W-1:0] DUP_SAT      = 4'd15;

   localparam logic [DUP_W-1:0]      CFG_DUP_RESET     = 4'd3;
   localparam logic [CSR_DATA_W-1:0] CFG_INIT_RESET    = 16'd1;
   localparam logic [CSR_DATA_W-1:0] CFG_RESTART_RESET = 16'd10;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_DUP_THRESH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_WIN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTART_WIN = 2'd2;

   // event codes on the request channel
   localparam logic [ACTION_W-1:0] ACT_NEW_ACK = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DUP_ACK = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TIMEOUT = 2'd2;

   typedef enum logic [1:0] {
      PH_SLOW  = 2'd0,
      PH_AVOID = 2'd1,
      PH_RECOV = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CMD_NEW_ACK,
      CMD_DUP_ACK,
      CMD_TIMEOUT,
      CMD_NONE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [ACK_W-1:0] count;
   } cmd_type;

endpackage

`default_nettype wire

### rtl/core/tcpr_front.sv
// Front end: takes requests, classifies the event and queues commands for the back end.
`default_nettype none

module tcpr_front #(
   parameter int DEPTH = tcpr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [tcpr_pkg::ACTION_W-1:0] req_action,
   input  wire logic [tcpr_pkg::ACK_W-1:0]    req_acked_count,
   output logic                               q_valid,
   input  wire logic                          q_ready,
   output tcpr_pkg::cmd_type                  q_item
);
   import tcpr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            q_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   cmd_type            cmd_in;
   logic               push;
   logic               pop;

   always_comb begin
      cmd_in.count = req_acked_count;
      unique case (req_action)
         ACT_NEW_ACK: cmd_in.kind = CMD_NEW_ACK;
         ACT_DUP_ACK: cmd_in.kind = CMD_DUP_ACK;
         ACT_TIMEOUT: cmd_in.kind = CMD_TIMEOUT;
         default:     cmd_in.kind = CMD_NONE;
      endcase
   end

   assign req_ready = (count_ff != CNT_W'(DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/tcpr_back.sv
// Back end: window state, configuration registers, avoidance loop and response register.
`default_nettype none

module tcpr_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   output logic                                 q_ready,
   input  wire tcpr_pkg::cmd_type               q_item,
   input  wire logic                            csr_valid,
   input  wire logic [tcpr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tcpr_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [tcpr_pkg::WIN_W-1:0]           rsp_window,
   output logic [tcpr_pkg::WIN_W-1:0]           rsp_slow_start_threshold,
   output logic [1:0]                           rsp_phase,
   output logic                                 rsp_in_fast_recovery
);
   import tcpr_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_LOOP, ST_DONE} state_type;

   state_type              state_ff;
   phase_type              phase_ff;
   logic [WIN_W-1:0]       window_ff;
   logic [WIN_W-1:0]       thr_ff;
   logic [DUP_W-1:0]       dup_ff;
   logic [WIN_W-1:0]       credit_ff;
   logic [WIN_W+1:0]       sum_ff;
   logic                   fresh_ff;
   logic [DUP_W-1:0]       cfg_dup_ff;
   logic [CSR_DATA_W-1:0]  cfg_restart_ff;

   logic                   rsp_valid_ff;
   logic [WIN_W-1:0]       rsp_window_ff;
   logic [WIN_W-1:0]       rsp_thr_ff;
   phase_type              rsp_phase_ff;

   logic [WIN_W:0]         grown;
   logic [WIN_W:0]         carry;
   logic [WIN_W+1:0]       avoid_sum;
   logic [DUP_W-1:0]       dup_in;
   logic [WIN_W-1:0]       half_plus_one;
   logic [WIN_W+1:0]       win_ext;
   logic                   take_step;
   logic                   go_loop;

   assign grown         = {1'b0, window_ff} + (WIN_W+1)'(q_item.count);
   assign carry         = grown - {1'b0, thr_ff};
   assign avoid_sum     = {2'b00, credit_ff} + (WIN_W+2)'(q_item.count);
   assign dup_in        = (dup_ff == DUP_SAT) ? dup_ff : dup_ff + DUP_W'(1);
   assign half_plus_one = {1'b0, window_ff[WIN_W-1:1]} + WIN_W'(1);
   assign win_ext       = {2'b00, window_ff};
   // one window increment per cycle while the credit covers a full window and the window is below its maximum
   assign take_step     = (sum_ff >= win_ext) && (window_ff != WIN_MAX);
   // a new ack runs the avoidance loop unless it stays inside slow start
   assign go_loop       = (q_item.kind == CMD_NEW_ACK) &&
                          ((phase_ff != PH_SLOW) || (grown >= {1'b0, thr_ff}));

   assign q_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_SLOW;
         window_ff      <= WIN_W'(CFG_INIT_RESET);
         thr_ff         <= THRESH_RESET;
         dup_ff         <= '0;
         credit_ff      <= '0;
         sum_ff         <= '0;
         fresh_ff       <= 1'b1;
         cfg_dup_ff     <= CFG_DUP_RESET;
         cfg_restart_ff <= CFG_RESTART_RESET;
         rsp_valid_ff   <= 1'b0;
         rsp_window_ff  <= '0;
         rsp_thr_ff     <= '0;
         rsp_phase_ff   <= PH_SLOW;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  state_ff <= go_loop ? ST_LOOP : ST_DONE;
                  if (q_item.kind != CMD_NONE) begin
                     fresh_ff <= 1'b0;
                  end
                  unique case (q_item.kind)
                     CMD_NEW_ACK: begin
                        dup_ff <= '0;
                        unique case (phase_ff)
                           PH_SLOW: begin
                              if (grown >= {1'b0, thr_ff}) begin
                                 window_ff <= thr_ff;
                                 credit_ff <= '0;
                                 phase_ff  <= PH_AVOID;
                                 sum_ff    <= (WIN_W+2)'(carry);
                              end else begin
                                 window_ff <= grown[WIN_W-1:0];
                              end
                           end
                           PH_RECOV: begin
                              window_ff <= thr_ff;
                              credit_ff <= '0;
                              phase_ff  <= PH_AVOID;
                              sum_ff    <= (WIN_W+2)'(q_item.count);
                           end
                           default: begin
                              sum_ff <= avoid_sum;
                           end
                        endcase
                     end
                     CMD_DUP_ACK: begin
                        if (phase_ff == PH_RECOV) begin
                           if (window_ff != WIN_MAX) begin
                              window_ff <= window_ff + WIN_W'(1);
                           end
                        end else begin
                           dup_ff <= dup_in;
                           if (dup_in == cfg_dup_ff) begin
                              thr_ff    <= half_plus_one;
                              window_ff <= half_plus_one + RECOV_BONUS;
                              phase_ff  <= PH_RECOV;
                           end
                        end
                     end
                     CMD_TIMEOUT: begin
                        dup_ff    <= '0;
                        thr_ff    <= half_plus_one;
                        window_ff <= WIN_W'(cfg_restart_ff);
                        phase_ff  <= PH_SLOW;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_LOOP: begin
               if (take_step) begin
                  sum_ff    <= sum_ff - win_ext;
                  window_ff <= window_ff + WIN_W'(1);
               end else begin
                  credit_ff <= (sum_ff > {2'b00, WIN_MAX}) ? WIN_MAX : sum_ff[WIN_W-1:0];
                  state_ff  <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_window_ff <= window_ff;
                  rsp_thr_ff    <= thr_ff;
                  rsp_phase_ff  <= phase_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // csr writes must arrive only while the block is idle; the block itself does not enforce this
         if (csr_valid) begin
            unique case (csr_index)
               CSR_DUP_THRESH: cfg_dup_ff <= csr_data[DUP_W-1:0];
               CSR_INIT_WIN: begin
                  if (fresh_ff) begin
                     window_ff <= WIN_W'(csr_data);
                  end
               end
               CSR_RESTART_WIN: cfg_restart_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_window               = rsp_window_ff;
   assign rsp_slow_start_threshold = rsp_thr_ff;
   assign rsp_phase                = rsp_phase_ff;
   assign rsp_in_fast_recovery     = (rsp_phase_ff == PH_RECOV);

endmodule

`default_nettype wire

### rtl/core/tcp_reno_congestion_window.sv
// Top level of the TCP Reno congestion window controller.
//
//  Channel | Ports                                            | Dir | Moves
//  --------+--------------------------------------------------+-----+--------------------------
//  req     | req_valid/ready, req_action, req_acked_count     | in  | one event per request
//  rsp     | rsp_valid/ready, rsp_window, rsp_slow_start_     | out | one result per request
//          | threshold, rsp_phase, rsp_in_fast_recovery       |     |
//  csr     | csr_valid/ready, csr_index, csr_data             | in  | one register write
//
// The back end takes a request in ST_IDLE and registers its response in ST_DONE; a new ack
// that reaches congestion avoidance runs ST_LOOP in between, which makes the window increments
// (one ack carries at most 65535 packets); the loop does one subtract-and-compare a cycle.
// With an empty queue a request still passes the queue register before the back end takes it.
// Reset is synchronous; there is no clearing pass.
// The command queue lets requests be taken while the back end is busy or a response waits;
// csr_ready is always high.
`default_nettype none

module tcp_reno_congestion_window #(
   parameter int QUEUE_DEPTH = tcpr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [tcpr_pkg::ACTION_W-1:0]   req_action,
   input  wire logic [tcpr_pkg::ACK_W-1:0]      req_acked_count,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [tcpr_pkg::WIN_W-1:0]           rsp_window,
   output logic [tcpr_pkg::WIN_W-1:0]           rsp_slow_start_threshold,
   output logic [1:0]                           rsp_phase,
   output logic                                 rsp_in_fast_recovery,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [tcpr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tcpr_pkg::CSR_DATA_W-1:0] csr_data
);
   import tcpr_pkg::*;

   logic    q_valid;
   logic    q_ready;
   cmd_type q_item;

   assign csr_ready = 1'b1;

   tcpr_front #(
      .DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_acked_count (req_acked_count),
      .q_valid         (q_valid),
      .q_ready         (q_ready),
      .q_item          (q_item)
   );

   tcpr_back u_back (
      .clock                    (clock),
      .reset                    (reset),
      .q_valid                  (q_valid),
      .q_ready                  (q_ready),
      .q_item                   (q_item),
      .csr_valid                (csr_valid),
      .csr_index                (csr_index),
      .csr_data                 (csr_data),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_window               (rsp_window),
      .rsp_slow_start_threshold (rsp_slow_start_threshold),
      .rsp_phase                (rsp_phase),
      .rsp_in_fast_recovery     (rsp_in_fast_recovery)
   );

endmodule

`default_nettype wire

### rtl/core/tcpr_checker.sv
// Port-level checks on the congestion window controller, bound to the top level.
`default_nettype none

module tcpr_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [tcpr_pkg::WIN_W-1:0]      rsp_window,
   input wire logic [tcpr_pkg::WIN_W-1:0]      rsp_slow_start_threshold,
   input wire logic [1:0]                      rsp_phase,
   input wire logic                            rsp_in_fast_recovery
);
   import tcpr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_window) && $stable(rsp_slow_start_threshold))
      else $error("stalled response changed");

   a_recov_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_in_fast_recovery == (rsp_phase == PH_RECOV)))
      else $error("fast recovery flag disagrees with phase");

   a_recov_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_fast_recovery |->
         ({1'b0, rsp_window} >= ({1'b0, rsp_slow_start_threshold} + 33'd3)))
      else $error("fast recovery window below threshold plus three");

   a_avoid_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == PH_AVOID) |-> (rsp_window != '0))
      else $error("zero window in congestion avoidance");

endmodule

bind tcp_reno_congestion_window tcpr_checker u_tcpr_checker (
   .clock                    (clock),
   .reset                    (reset),
   .rsp_valid                (rsp_valid),
   .rsp_ready                (rsp_ready),
   .rsp_window               (rsp_window),
   .rsp_slow_start_threshold (rsp_slow_start_threshold),
   .rsp_phase                (rsp_phase),
   .rsp_in_fast_recovery     (rsp_in_fast_recovery)
);

`default_nettype wire
